// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/sla_pkg.sv =====
package sla_pkg;

  localparam int LINE_STORE_DEPTH = 64;
  localparam int ADDR_W = $clog2(LINE_STORE_DEPTH);
  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [7:0] CHR_CR = 8'd13;
  localparam logic [7:0] CHR_LF = 8'd10;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_EOL      = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== sv/serial_line_assembler.sv =====
// Collects received bytes into a line store and hands a line out when a CR or
// LF ends it: the stored characters, cut to cfg capacity minus one, then an
// end-of-line word with last set. A non-terminator byte arriving with 63 bytes held
// gives one overflow word and empties the line. An ordinary byte is taken whenever
// the block is idle. A terminator with characters to send holds the input stalled
// while the line is dumped, one result per cycle while out_stall stays low; the
// single read port of the line store paces the dump. Results sit in an output
// register, so a new byte is taken while the last result still waits there.
`include "assert_macros.svh"

module serial_line_assembler (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [sla_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                result_kind,
  output logic [7:0]                line_char,
  output logic                      last
);
  import sla_pkg::*;

  logic [CAP_W-1:0] line_capacity;
  ram_req_t         ram_req;
  logic [7:0]       rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      line_capacity <= cfg_wr_data;
    end
  end

  sla_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  sla_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cap         (line_capacity),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .line_char   (line_char),
    .last        (last),
    .ram_req     (ram_req),
    .rd_data     (rd_data)
  );

  `ASSERT_IMPLIES(a_marker_is_last, clk, rst, out_valid && (result_kind != KIND_CHAR), last)
  `ASSERT_IMPLIES(a_char_not_last, clk, rst, out_valid && (result_kind == KIND_CHAR), !last)
  `ASSERT_IMPLIES(a_marker_no_char, clk, rst, out_valid && (result_kind != KIND_CHAR), line_char == 8'd0)
  `ASSERT_IMPLIES(a_no_store_rw, clk, rst, ram_req.we, !ram_req.re)

endmodule

// ===== sv/sla_ram.sv =====
module sla_ram (
  input  logic             clk,
  input  sla_pkg::ram_req_t req,
  output logic [7:0]       rd_data
);
  import sla_pkg::*;

  logic [7:0] mem [LINE_STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== sv/sla_ctrl.sv =====
module sla_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [sla_pkg::CAP_W-1:0] cap,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                result_kind,
  output logic [7:0]                line_char,
  output logic                      last,
  output sla_pkg::ram_req_t         ram_req,
  input  logic [7:0]                rd_data
);
  import sla_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DUMP = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(LINE_STORE_DEPTH - 1);

  logic [1:0]        state, state_next;
  logic [ADDR_W-1:0] fill, fill_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [ADDR_W-1:0] len, len_next;
  logic              data_ok, data_ok_next;

  logic              out_valid_next;
  logic [1:0]        result_kind_next;
  logic [7:0]        line_char_next;
  logic              last_next;

  logic              out_free;
  logic              in_acc;
  logic              is_term;
  logic [CAP_W-1:0]  limit;
  logic [ADDR_W-1:0] len_calc;
  logic              do_read;

  always_comb begin
    out_free = !out_valid || !out_stall;
    in_stall = (state != ST_IDLE);
    in_acc   = in_valid && !in_stall;
    is_term  = (rx_byte == CHR_CR) || (rx_byte == CHR_LF);
    limit    = (cap == '0) ? '0 : cap - CAP_W'(1);
    len_calc = (CAP_W'(fill) < limit) ? fill : limit[ADDR_W-1:0];
    do_read  = (state == ST_DUMP) && (idx != len) && (!data_ok || out_free);

    ram_req.we    = in_acc && !is_term && (fill != FILL_MAX);
    ram_req.waddr = fill;
    ram_req.wdata = rx_byte;
    ram_req.re    = do_read;
    ram_req.raddr = idx;

    state_next       = state;
    fill_next        = fill;
    idx_next         = idx;
    len_next         = len;
    data_ok_next     = data_ok;
    out_valid_next   = out_valid && out_stall;
    result_kind_next = result_kind;
    line_char_next   = line_char;
    last_next        = last;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_term) begin
            if (fill != '0) begin
              fill_next    = '0;
              idx_next     = '0;
              len_next     = len_calc;
              data_ok_next = 1'b0;
              state_next   = ST_DUMP;
            end
          end else if (fill != FILL_MAX) begin
            fill_next = fill + ADDR_W'(1);
          end else begin
            fill_next  = '0;
            state_next = ST_OVF;
          end
        end
      end
      ST_DUMP: begin
        if (data_ok && out_free) begin
          out_valid_next   = 1'b1;
          result_kind_next = KIND_CHAR;
          line_char_next   = rd_data;
          last_next        = 1'b0;
        end else if (!data_ok && (idx == len) && out_free) begin
          out_valid_next   = 1'b1;
          result_kind_next = KIND_EOL;
          line_char_next   = '0;
          last_next        = 1'b1;
          state_next       = ST_IDLE;
        end
        if (do_read) begin
          idx_next     = idx + ADDR_W'(1);
          data_ok_next = 1'b1;
        end else if (data_ok && out_free) begin
          data_ok_next = 1'b0;
        end
      end
      ST_OVF: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          result_kind_next = KIND_OVERFLOW;
          line_char_next   = '0;
          last_next        = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      data_ok   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      data_ok   <= data_ok_next;
      out_valid <= out_valid_next;
    end
    idx         <= idx_next;
    len         <= len_next;
    result_kind <= result_kind_next;
    line_char   <= line_char_next;
    last        <= last_next;
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 70;
  localparam int PHASE_BYTES = 20;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {ROW_BYTE, ROW_CFG} row_op_e;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_EOL, EXP_OVERFLOW} exp_mode_e;

  typedef struct {
    row_op_e    op;
    logic [7:0] val;
    int         reps;
    exp_mode_e  mode;
  } stim_row_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } line_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           result_kind;
  logic [7:0]           line_char;
  logic                 last;

  // predictor state
  logic [7:0]           line_buf [LINE_STORE_DEPTH];
  int                   line_fill = 0;
  logic [CAP_W-1:0]     cap_reg = CAP_RESET;

  line_word_t           expected_words [$];
  stim_row_t            stim_rows [22];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int lines_done = 0;
  int overflows = 0;
  int cfg_writes = 0;

  serial_line_assembler DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .line_char(line_char),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void push_word(logic [1:0] kind, logic [7:0] ch, logic lst);
    line_word_t w;
    w.kind = kind;
    w.ch = ch;
    w.last = lst;
    expected_words.push_back(w);
  endfunction

  function automatic void assemble_line(logic [7:0] b, bit record);
    int lim;
    int n;
    if (b == CHR_CR || b == CHR_LF) begin
      if (line_fill == 0) return;
      lim = (cap_reg == 0) ? 0 : int'(cap_reg) - 1;
      n = line_fill;
      if (n > lim) n = lim;
      if (n > LINE_STORE_DEPTH - 1) n = LINE_STORE_DEPTH - 1;
      if (record) begin
        for (int i = 0; i < n; i++) push_word(KIND_CHAR, line_buf[i], 1'b0);
        push_word(KIND_EOL, 8'd0, 1'b1);
      end
      line_fill = 0;
      lines_done++;
    end else if (line_fill < LINE_STORE_DEPTH - 1) begin
      line_buf[line_fill] = b;
      line_fill++;
    end else begin
      line_fill = 0;
      if (record) push_word(KIND_OVERFLOW, 8'd0, 1'b1);
      overflows++;
    end
  endfunction

  task automatic send_byte(logic [7:0] b, exp_mode_e mode);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    assemble_line(b, mode == EXP_MODEL);
    case (mode)
      EXP_EOL: push_word(KIND_EOL, 8'd0, 1'b1);
      EXP_OVERFLOW: push_word(KIND_OVERFLOW, 8'd0, 1'b1);
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = v;
    cfg_writes++;
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CHR_CR || b == CHR_LF) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic random_phase(int budget);
    int start;
    int r;
    int len;
    bit paused;
    start = bytes_sent;
    paused = 0;
    while (bytes_sent - start < budget) begin
      if (!paused && bytes_sent - start >= budget / 2) begin
        drain();
        paused = 1;
      end
      r = $urandom_range(99);
      if (r < 70) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 63) : $urandom_range(1, 12);
        repeat (len) send_byte(body_byte(), EXP_MODEL);
        send_byte($urandom_range(1) ? CHR_CR : CHR_LF, EXP_MODEL);
      end else if (r < 80) begin
        repeat (LINE_STORE_DEPTH) send_byte(body_byte(), EXP_MODEL);
        send_byte($urandom_range(1) ? CHR_CR : CHR_LF, EXP_MODEL);
      end else if (r < 90) begin
        send_byte($urandom_range(1) ? CHR_CR : CHR_LF, EXP_MODEL);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), EXP_MODEL);
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  // compare each delivered word with the oldest expectation
  always @(posedge clk) begin
    line_word_t w;
    if (!rst && out_valid && !out_stall) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected word: kind %0d char %02h last %0d",
                   result_kind, line_char, last);
      end else begin
        w = expected_words.pop_front();
        if (result_kind !== w.kind || line_char !== w.ch || last !== w.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: kind %0d/%0d char %02h/%02h last %0d/%0d (exp/got)",
                     w.kind, result_kind, w.ch, line_char, w.last, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stim_rows[0]  = '{ROW_BYTE, CHR_CR, 1, EXP_NONE};
    stim_rows[1]  = '{ROW_BYTE, CHR_LF, 1, EXP_NONE};
    stim_rows[2]  = '{ROW_BYTE, 8'h00, 1, EXP_MODEL};
    stim_rows[3]  = '{ROW_BYTE, 8'hFF, 1, EXP_MODEL};
    stim_rows[4]  = '{ROW_BYTE, CHR_CR, 1, EXP_MODEL};
    stim_rows[5]  = '{ROW_BYTE, 8'h41, 1, EXP_MODEL};
    stim_rows[6]  = '{ROW_BYTE, CHR_LF, 1, EXP_MODEL};
    stim_rows[7]  = '{ROW_CFG, 8'd1, 1, EXP_NONE};
    stim_rows[8]  = '{ROW_BYTE, 8'h78, 2, EXP_MODEL};
    stim_rows[9]  = '{ROW_BYTE, CHR_CR, 1, EXP_EOL};
    stim_rows[10] = '{ROW_CFG, 8'd0, 1, EXP_NONE};
    stim_rows[11] = '{ROW_BYTE, 8'h7A, 1, EXP_MODEL};
    stim_rows[12] = '{ROW_BYTE, CHR_LF, 1, EXP_EOL};
    stim_rows[13] = '{ROW_CFG, 8'd3, 1, EXP_NONE};
    stim_rows[14] = '{ROW_BYTE, 8'h80, 4, EXP_MODEL};
    stim_rows[15] = '{ROW_BYTE, CHR_CR, 1, EXP_MODEL};
    stim_rows[16] = '{ROW_CFG, 8'd127, 1, EXP_NONE};
    stim_rows[17] = '{ROW_BYTE, 8'h5A, 5, EXP_MODEL};
    stim_rows[18] = '{ROW_BYTE, CHR_LF, 1, EXP_MODEL};
    stim_rows[19] = '{ROW_BYTE, 8'hC3, 63, EXP_MODEL};
    stim_rows[20] = '{ROW_BYTE, 8'h07, 1, EXP_OVERFLOW};
    stim_rows[21] = '{ROW_BYTE, CHR_CR, 1, EXP_NONE};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle_pct = 9;
    rcv_idle_pct = 76;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].op == ROW_CFG)
        write_capacity(stim_rows[i].val[CAP_W-1:0]);
      else
        repeat (stim_rows[i].reps) send_byte(stim_rows[i].val, stim_rows[i].mode);
    end

    write_capacity(CAP_W'($urandom_range(2, 63)));
    random_phase(PHASE_BYTES);

    write_capacity(CAP_W'($urandom_range(0, 127)));
    snd_idle_pct = 76;
    rcv_idle_pct = 9;
    random_phase(PHASE_BYTES);

    write_capacity(CAP_RESET);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_phase(PHASE_BYTES);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) fail_count++;

    $display("run: %0d bytes in, %0d words checked, %0d lines, %0d overflows",
             bytes_sent, words_checked, lines_done, overflows);
    $display("run: %0d capacity writes over three stall patterns, %0d failures",
             cfg_writes, fail_count);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
